[rtl/core/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Counter width default (tick counter of trigger, wait and echo phases)
  localparam int unsigned COUNT_BITS_DEF = 18;

  // Register widths
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned ECHO_W   = 18;
  localparam int unsigned TPU_W    = 8;
  localparam int unsigned DIST_W   = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST     = TRIG_W'(10);
  localparam logic [WAIT_W-1:0] WAIT_LIMIT_RST     = WAIT_W'(20000);
  localparam logic [ECHO_W-1:0] ECHO_LIMIT_RST     = ECHO_W'(205824);
  localparam logic [TPU_W-1:0]  TICKS_PER_UNIT_RST = TPU_W'(58);

  // Saturated / no-echo distance
  localparam logic [DIST_W-1:0] FAR_UNITS = '1;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_TRIGGER_WIDTH  = 2'd0,
    CFG_WAIT_LIMIT     = 2'd1,
    CFG_ECHO_LIMIT     = 2'd2,
    CFG_TICKS_PER_UNIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_width;
    logic [WAIT_W-1:0] wait_limit;
    logic [ECHO_W-1:0] echo_limit;
    logic [TPU_W-1:0]  ticks_per_unit;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance;
    logic              timed_out;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/uer_if.sv]
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels of the echo ranger: tick input, result, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_req_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_res_if import uer_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              busy_res;
  logic              done_res;
  logic [DIST_W-1:0] distance;
  logic              timed_out;

  modport source (output valid, output trigger, output busy_res, output done_res,
                  output distance, output timed_out, input ready);
  modport sink   (input valid, input trigger, input busy_res, input done_res,
                  input distance, input timed_out, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*; ;
  logic                  valid;
  logic                  ready;
  cfg_idx_e              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/uer_fsm.sv]
// ----------------------------------------------------------------------------
// uer_fsm
// Measurement sequencer: trigger, echo wait, echo timing with prescaler.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_fsm import uer_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  step_i,      // process the staged tick
  input  wire  start_req_i,
  input  wire  echo_i,
  input  cfg_t cfg_i,
  output res_t res_o        // result of the staged tick
);

  localparam int unsigned CMP_W = (COUNT_BITS > ECHO_W) ? COUNT_BITS : ECHO_W;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_ECHO = 2'd3
  } phase_e;

  phase_e                  ph_q, ph_d, ph_m;
  logic [COUNT_BITS-1:0]   tick_q, tick_d, tick_m;
  logic [TPU_W-1:0]        pre_q, pre_d;
  logic [DIST_W-1:0]       unit_q, unit_d;
  logic [DIST_W-1:0]       dist_q, dist_d;
  logic                    tmo_q, tmo_d;

  logic                    trig;
  logic                    done;

  // echo tick counting
  logic [COUNT_BITS-1:0]   tick_b;
  logic [TPU_W-1:0]        pre_b, pre_inc;
  logic [DIST_W-1:0]       unit_b;
  logic                    unit_wrap;
  logic [COUNT_BITS-1:0]   tick_c;
  logic [TPU_W-1:0]        pre_c;
  logic [DIST_W-1:0]       unit_c;
  logic                    wait_to, echo_to;

  always_comb begin
    // first half: start and trigger
    ph_m   = ph_q;
    tick_m = tick_q;
    trig   = 1'b0;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_req_i) begin
          ph_m   = PH_TRIG;
          tick_m = CNT_ONE;
          trig   = 1'b1;
        end
      end
      PH_TRIG: begin
        if (tick_q < COUNT_BITS'(cfg_i.trigger_width)) begin
          tick_m = tick_q + CNT_ONE;
          trig   = 1'b1;
        end else begin
          ph_m   = PH_WAIT;
          tick_m = '0;
        end
      end
      default: ;
    endcase

    // one echo tick, from zero on entry to the echo phase
    tick_b    = (ph_m == PH_WAIT) ? '0 : tick_q;
    pre_b     = (ph_m == PH_WAIT) ? '0 : pre_q;
    unit_b    = (ph_m == PH_WAIT) ? '0 : unit_q;
    tick_c    = tick_b + CNT_ONE;
    pre_inc   = pre_b + TPU_W'(1);
    unit_wrap = (pre_inc >= cfg_i.ticks_per_unit);
    pre_c     = unit_wrap ? '0 : pre_inc;
    unit_c    = (unit_wrap && (unit_b != FAR_UNITS)) ? unit_b + DIST_W'(1) : unit_b;

    wait_to = (tick_m >= COUNT_BITS'(cfg_i.wait_limit)) || (&tick_m);
    echo_to = (CMP_W'(tick_q) >= CMP_W'(cfg_i.echo_limit)) || (&tick_q);

    // second half: wait and timing
    ph_d   = ph_m;
    tick_d = tick_m;
    pre_d  = pre_q;
    unit_d = unit_q;
    dist_d = dist_q;
    tmo_d  = tmo_q;
    done   = 1'b0;

    if (ph_m == PH_WAIT) begin
      if (echo_i) begin
        ph_d   = PH_ECHO;
        tick_d = tick_c;
        pre_d  = pre_c;
        unit_d = unit_c;
      end else if (wait_to) begin
        dist_d = FAR_UNITS;
        tmo_d  = 1'b1;
        done   = 1'b1;
      end else begin
        tick_d = tick_m + CNT_ONE;
      end
    end else if (ph_m == PH_ECHO) begin
      if (!echo_i) begin
        dist_d = unit_q;
        tmo_d  = 1'b0;
        done   = 1'b1;
      end else if (echo_to) begin
        dist_d = FAR_UNITS;
        tmo_d  = 1'b1;
        done   = 1'b1;
      end else begin
        tick_d = tick_c;
        pre_d  = pre_c;
        unit_d = unit_c;
      end
    end

    if (done) begin
      ph_d   = PH_IDLE;
      tick_d = '0;
      pre_d  = '0;
      unit_d = '0;
    end

    res_o.trigger   = trig;
    res_o.busy_res  = (ph_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.distance  = dist_d;
    res_o.timed_out = tmo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tick_q <= '0;
      pre_q  <= '0;
      unit_q <= '0;
      dist_q <= FAR_UNITS;
      tmo_q  <= 1'b0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      tick_q <= tick_d;
      pre_q  <= pre_d;
      unit_q <= unit_d;
      dist_q <= dist_d;
      tmo_q  <= tmo_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ultrasonic_echo_ranger_top.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Echo-time ranging: one input transaction per microsecond tick, one result
// transaction per tick with trigger drive, status and the last distance.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                       | handshake
//  --------+-----+-----------------------------------------------+----------
//  req_i   | in  | start_req, echo                               | valid/ready
//  res_o   | out | trigger, busy_res, done_res, distance, t/o    | valid/ready
//  cfg_i   | in  | index (cfg_idx_e), data                       | valid/ready
//
//  One tick per clock sustained while results are taken. A tick is held in
//  the input stage, then the sequencer updates its state and loads the
//  result register, which drives res_o.
//  rst_ni clears the sequencer (idle, distance 255) and restores register
//  defaults. A stalled result holds the pipe; the input stage still takes a
//  tick while the result register drains. cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_top import uer_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  uer_req_if.sink   req_i,
  uer_res_if.source res_o,
  uer_cfg_if.sink   cfg_i
);

  // Input stage
  logic s1_valid_q;
  logic s1_start_q;
  logic s1_echo_q;

  // Result register
  logic out_valid_q;
  res_t out_q;

  // Config registers
  cfg_t cfg_q;

  res_t step_res;
  logic advance;   // staged tick moves into the result register

  assign advance     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_start_q <= req_i.start_req;
      s1_echo_q  <= req_i.echo;
    end
  end

  // Register writes, values truncated to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_width  <= TRIG_WIDTH_RST;
      cfg_q.wait_limit     <= WAIT_LIMIT_RST;
      cfg_q.echo_limit     <= ECHO_LIMIT_RST;
      cfg_q.ticks_per_unit <= TICKS_PER_UNIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TRIGGER_WIDTH:  cfg_q.trigger_width  <= cfg_i.data[TRIG_W-1:0];
        CFG_WAIT_LIMIT:     cfg_q.wait_limit     <= cfg_i.data[WAIT_W-1:0];
        CFG_ECHO_LIMIT:     cfg_q.echo_limit     <= cfg_i.data[ECHO_W-1:0];
        CFG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_i.data[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  uer_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .start_req_i (s1_start_q),
    .echo_i      (s1_echo_q),
    .cfg_i       (cfg_q),
    .res_o       (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.trigger   = out_q.trigger;
  assign res_o.busy_res  = out_q.busy_res;
  assign res_o.done_res  = out_q.done_res;
  assign res_o.distance  = out_q.distance;
  assign res_o.timed_out = out_q.timed_out;

endmodule

`default_nettype wire

[tb/sv/uer_ranging_checker.sv]
// ----------------------------------------------------------------------------
// uer_ranging_checker
// Watches the tick, result and register channels of the echo ranger, predicts
// every per-tick status transaction and compares it field by field.
// ----------------------------------------------------------------------------
module uer_ranging_checker import uer_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  uer_req_if   req_i,
  uer_res_if   res_i,
  uer_cfg_if   cfg_i,
  input  logic end_check_i,
  output int   pending_o,
  output int   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;
  localparam int unsigned PRINT_CAP = 40;

  typedef enum logic [1:0] {
    RG_IDLE,
    RG_TRIGGER,
    RG_LISTEN,
    RG_ECHO
  } ranging_phase_e;

  // Shadow registers and sequencer state
  cfg_t                  regs;
  ranging_phase_e        rg_phase;
  logic [COUNT_BITS-1:0] tick_cnt;
  logic [7:0]            pre_cnt;
  logic [DIST_W-1:0]     unit_cnt;
  logic [DIST_W-1:0]     last_dist;
  logic                  last_tmo;

  res_t        expected_status_q[$];
  int unsigned results_seen;
  int unsigned meas_done;
  int unsigned meas_timeout;
  int unsigned meas_far;
  int unsigned reg_writes;

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    // printing is capped so a dead design cannot flood the log
    if (fail_count_o < PRINT_CAP)
      $display("[%0t] MISMATCH %s at result %0d: got %0d, expected %0d",
               $time, what, results_seen, got, want);
    fail_count_o++;
  endtask

  function automatic void count_echo_tick();
    tick_cnt = tick_cnt + 1'b1;
    pre_cnt  = pre_cnt + 1'b1;
    if (pre_cnt >= regs.ticks_per_unit) begin
      pre_cnt = '0;
      if (unit_cnt != FAR_UNITS) unit_cnt = unit_cnt + 1'b1;
    end
  endfunction

  function automatic void end_measurement(logic [DIST_W-1:0] dist_val, logic tmo);
    last_dist = dist_val;
    last_tmo  = tmo;
    rg_phase  = RG_IDLE;
    tick_cnt  = '0;
    pre_cnt   = '0;
    unit_cnt  = '0;
  endfunction

  // One microsecond tick of the ranging sequencer.
  function automatic res_t ranging_tick(logic start, logic echo_lvl);
    res_t r;
    logic trig;
    logic done;
    trig = 1'b0;
    done = 1'b0;
    if (rg_phase == RG_IDLE) begin
      if (start) begin
        rg_phase = RG_TRIGGER;
        tick_cnt = COUNT_BITS'(1);
        trig     = 1'b1;
      end
    end else if (rg_phase == RG_TRIGGER) begin
      if (tick_cnt < regs.trigger_width) begin
        tick_cnt = tick_cnt + 1'b1;
        trig     = 1'b1;
      end else begin
        // first low-trigger tick is already a listening tick
        rg_phase = RG_LISTEN;
        tick_cnt = '0;
      end
    end

    if (rg_phase == RG_LISTEN && !trig) begin
      if (echo_lvl) begin
        rg_phase = RG_ECHO;
        tick_cnt = '0;
        pre_cnt  = '0;
        unit_cnt = '0;
        count_echo_tick();
      end else if (tick_cnt >= regs.wait_limit || tick_cnt == TICK_MAX) begin
        end_measurement(FAR_UNITS, 1'b1);
        done = 1'b1;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else if (rg_phase == RG_ECHO) begin
      if (!echo_lvl) begin
        end_measurement(unit_cnt, 1'b0);
        done = 1'b1;
      end else if (tick_cnt >= regs.echo_limit || tick_cnt == TICK_MAX) begin
        end_measurement(FAR_UNITS, 1'b1);
        done = 1'b1;
      end else begin
        count_echo_tick();
      end
    end

    r.trigger   = trig;
    r.busy_res  = (rg_phase != RG_IDLE);
    r.done_res  = done;
    r.distance  = last_dist;
    r.timed_out = last_tmo;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t pred;
    if (!rst_ni) begin
      regs.trigger_width  = TRIG_WIDTH_RST;
      regs.wait_limit     = WAIT_LIMIT_RST;
      regs.echo_limit     = ECHO_LIMIT_RST;
      regs.ticks_per_unit = TICKS_PER_UNIT_RST;
      end_measurement(FAR_UNITS, 1'b0);
      expected_status_q.delete();
      results_seen = 0;
      meas_done    = 0;
      meas_timeout = 0;
      meas_far     = 0;
      reg_writes   = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        reg_writes++;
        case (cfg_i.index)
          CFG_TRIGGER_WIDTH:  regs.trigger_width  = cfg_i.data[TRIG_W-1:0];
          CFG_WAIT_LIMIT:     regs.wait_limit     = cfg_i.data[WAIT_W-1:0];
          CFG_ECHO_LIMIT:     regs.echo_limit     = cfg_i.data[ECHO_W-1:0];
          CFG_TICKS_PER_UNIT: regs.ticks_per_unit = cfg_i.data[TPU_W-1:0];
        endcase
      end

      // compare before pushing: a tick cannot produce its result on the same edge
      if (res_i.valid && res_i.ready) begin
        if (expected_status_q.size() == 0) begin
          note_mismatch("result with no tick outstanding", 0, 0);
        end else begin
          want = expected_status_q.pop_front();
          if (res_i.trigger !== want.trigger)
            note_mismatch("trigger", res_i.trigger, want.trigger);
          if (res_i.busy_res !== want.busy_res)
            note_mismatch("busy_res", res_i.busy_res, want.busy_res);
          if (res_i.done_res !== want.done_res)
            note_mismatch("done_res", res_i.done_res, want.done_res);
          if (res_i.distance !== want.distance)
            note_mismatch("distance", res_i.distance, want.distance);
          if (res_i.timed_out !== want.timed_out)
            note_mismatch("timed_out", res_i.timed_out, want.timed_out);
        end
        results_seen++;
      end

      if (req_i.valid && req_i.ready) begin
        pred = ranging_tick(req_i.start_req, req_i.echo);
        if (pred.done_res) begin
          meas_done++;
          if (pred.timed_out) meas_timeout++;
          else if (pred.distance == FAR_UNITS) meas_far++;
        end
        expected_status_q.push_back(pred);
      end
    end
    pending_o = expected_status_q.size();
  end

  always @(posedge end_check_i) begin
    if (expected_status_q.size() != 0)
      note_mismatch("results never delivered", 0, expected_status_q.size());
    $display("Covered %0d tick transactions and %0d register writes over several idle mixes.",
             results_seen, reg_writes);
    $display("Measurements finished: %0d, by timeout: %0d, saturated at far range: %0d.",
             meas_done, meas_timeout, meas_far);
  end

endmodule

[tb/sv/tb_ultrasonic_echo_ranger_top.sv]
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_top
// Stimulus and verdict for the echo ranger: directed corner cases, then
// random trigger/listen/echo sequences under several settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int unsigned PHASE_TICKS    = 30;    // minimum ticks per regular random phase
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned DRAIN_CYCLES   = 12;    // settle time after the last result

  // Phases with fully or partly fixed settings; the rest draw small random settings
  localparam int unsigned LOW_EXTREME_PHASE = 0;
  localparam int unsigned SATURATE_PHASE    = 3;
  localparam int unsigned SLOW_UNIT_PHASE   = 5;

  logic clk;
  logic rst_n;
  logic end_check;
  int   pending;
  int   fail_count;

  // idle mix, percent of cycles
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  int unsigned ticks_sent   = 0;
  int unsigned quiet_cycles = 0;

  // what was last programmed, used only to shape the stimulus
  int unsigned cur_tw  = TRIG_WIDTH_RST;
  int unsigned cur_wl  = WAIT_LIMIT_RST;
  int unsigned cur_el  = ECHO_LIMIT_RST;
  int unsigned cur_tpu = TICKS_PER_UNIT_RST;

  uer_req_if req_ch ();
  uer_res_if res_ch ();
  uer_cfg_if cfg_ch ();

  ultrasonic_echo_ranger_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  uer_ranging_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .cfg_i        (cfg_ch),
    .end_check_i  (end_check),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: ready toggles on the falling edge per the current stall mix
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: any accepted transaction on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One tick transaction. Called and returns on a falling edge; valid is left
  // high so back-to-back ticks never lower and raise it in the same step.
  task automatic send_tick(input logic start, input logic echo_lvl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.start_req <= start;
    req_ch.echo      <= echo_lvl;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every predicted result has been delivered.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Registers only change with the pipe empty, so no tick sees a half-applied
  // setting. All four are written every time.
  task automatic program_ranger(input logic [CFG_DATA_W-1:0] tw, wl, el, tpu);
    wait_drain();
    write_reg(CFG_TRIGGER_WIDTH, tw);
    write_reg(CFG_WAIT_LIMIT, wl);
    write_reg(CFG_ECHO_LIMIT, el);
    write_reg(CFG_TICKS_PER_UNIT, tpu);
    cfg_ch.valid <= 1'b0;
    cur_tw  = tw[TRIG_W-1:0];
    cur_wl  = wl[WAIT_W-1:0];
    cur_el  = el[ECHO_W-1:0];
    cur_tpu = tpu[TPU_W-1:0];
  endtask

  // A well-formed measurement with random content: start, trigger ticks with
  // stray restarts and echo glitches, a low listening stretch that sometimes
  // runs past the wait limit, then, unless that timed out, an echo pulse that
  // may overrun the echo limit, then the falling edge with a start to ignore.
  task automatic run_measurement(input int unsigned high_min, input int unsigned high_max);
    int unsigned low_n;
    int unsigned high_n;
    send_tick(1'b1, 1'($urandom));
    repeat ((cur_tw > 1) ? cur_tw - 1 : 0)
      send_tick(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 7) == 0));
    low_n = $urandom_range(0, (cur_wl < 30) ? cur_wl + 2 : 30);
    repeat (low_n) send_tick(1'($urandom_range(0, 7) == 0), 1'b0);
    if (low_n <= cur_wl) begin
      high_n = $urandom_range(high_min, (cur_el + 2 < high_max) ? cur_el + 2 : high_max);
      repeat (high_n) send_tick(1'($urandom_range(0, 7) == 0), 1'b1);
      send_tick(1'($urandom), 1'b0);
    end
  endtask

  initial begin
    int unsigned phase_first;

    // every input known from time zero
    req_ch.valid     <= 1'b0;
    req_ch.start_req <= 1'b0;
    req_ch.echo      <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_TRIGGER_WIDTH;
    cfg_ch.data      <= '0;
    end_check        <= 1'b0;
    rst_n            <= 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- Directed: reset settings (10-tick trigger, 58 ticks per unit) ----
    send_tick(1'b0, 1'b1);                 // echo while idle does nothing
    send_tick(1'b1, 1'b1);                 // start; echo ignored while triggering
    repeat (TRIG_WIDTH_RST - 1)
      send_tick(1'b1, 1'b1);               // restart requests ignored while busy
    repeat (3) send_tick(1'b0, 1'b1);      // short echo: 0 units
    send_tick(1'b1, 1'b0);                 // done tick: start there is dropped

    // Junk upper bits: every register masks down to zero
    program_ranger(32'hFFFF_FF00, 32'hFFFF_0000, 32'hFFFC_0000, 32'hABCD_EF00);
    // zero wait limit: first low listening tick times out
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // zero echo limit: second high tick after the start times out
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    // zero ticks per unit counts like one: a single echo tick gives 1 unit
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // ---- Random phases ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == LOW_EXTREME_PHASE) begin
        program_ranger(1, 1, 1, 1);
      end else if (ph == SATURATE_PHASE) begin
        // longest limits, one unit per tick so the count saturates
        program_ranger(16, 65535, 262143, 1);
      end else if (ph == SLOW_UNIT_PHASE) begin
        program_ranger($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(1, 48), 255);
      end else begin
        program_ranger($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(1, 48),
                       $urandom_range(1, 8));
      end

      // idle mix rotates: none, sender idle, receiver stalls, both
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase

      if (ph == SATURATE_PHASE) begin
        run_measurement(256, 262);
      end else begin
        phase_first = ticks_sent;
        while (ticks_sent - phase_first < PHASE_TICKS) begin
          // now and then the sender waits for the result pipe to empty
          if ($urandom_range(0, 9) == 0) wait_drain();
          // noise between measurements: mostly quiet ticks, sometimes garbage
          if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'($urandom));
          end else begin
            repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom));
          end
          run_measurement(1, 60);
        end
      end
    end

    // ---- Wind down and verdict ----
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    end_check <= 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/uer_pkg.sv
rtl/core/uer_if.sv
rtl/core/uer_fsm.sv
rtl/core/ultrasonic_echo_ranger_top.sv
tb/sv/uer_ranging_checker.sv
tb/sv/tb_ultrasonic_echo_ranger_top.sv
